@@ hw/rtl/altok_pkg.sv @@
// Shared types and constants for the assembly line tokenizer.
package altok_pkg;

  localparam int unsigned MaxResults = 3;

  // Lexer state codes
  localparam logic [3:0] LX_FIRST_LEAD    = 4'd0;
  localparam logic [3:0] LX_FIRST_DATA    = 4'd1;
  localparam logic [3:0] LX_FIRST_TRAIL   = 4'd2;
  localparam logic [3:0] LX_OPCODE_LEAD   = 4'd3;
  localparam logic [3:0] LX_OPCODE_DATA   = 4'd4;
  localparam logic [3:0] LX_OPCODE_TRAIL  = 4'd5;
  localparam logic [3:0] LX_OPERAND_LEAD  = 4'd6;
  localparam logic [3:0] LX_OPERAND_DATA  = 4'd7;
  localparam logic [3:0] LX_OPERAND_TRAIL = 4'd8;
  localparam logic [3:0] LX_COMMENT       = 4'd9;
  localparam logic [3:0] LX_ERROR         = 4'd10;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    RK_CHAR    = 2'd0,
    RK_END     = 2'd1,
    RK_ERROR   = 2'd2,
    RK_ABANDON = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    TT_LABEL   = 2'd0,
    TT_OPCODE  = 2'd1,
    TT_OPERAND = 2'd2
  } token_type_e;

  typedef struct packed {
    logic [7:0] input_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    result_kind_e result_kind;
    token_type_e  token_type;
    logic [7:0]   out_char;
    logic         last_result;
  } out_item_t;

  // All results caused by one byte, slot 0 first
  typedef struct packed {
    out_item_t [MaxResults-1:0] res;
    logic [1:0]                 cnt;
  } bundle_t;

endpackage

@@ hw/rtl/altok_lexer.sv @@
// Per-byte line lexer transition: next state and the results of one byte.
module altok_lexer (
  input  logic [3:0]          state_i,
  input  altok_pkg::in_item_t item_i,
  output logic [3:0]          state_o,
  output altok_pkg::bundle_t  bundle_o
);
  import altok_pkg::*;

  function automatic out_item_t mk_res(result_kind_e kind, token_type_e ty, logic [7:0] ch);
    out_item_t r;
    r.result_kind = kind;
    r.token_type  = ty;
    r.out_char    = ch;
    r.last_result = 1'b0;
    return r;
  endfunction

  logic [7:0]  c;
  logic        is_semi, is_nl, is_blank, is_colon, is_comma;
  token_type_e trail_ty;
  logic [3:0]  nxt;
  logic [3:0]  nxt_eot;
  out_item_t [MaxResults-1:0] res;
  logic [1:0]  n;

  assign c        = item_i.input_char;
  assign is_semi  = (c == CH_SEMI);
  assign is_nl    = (c == CH_NL);
  assign is_blank = (c inside {CH_SPACE, CH_TAB, CH_CR});
  assign is_colon = (c == CH_COLON);
  assign is_comma = (c == CH_COMMA);

  // Token type closed by a separator in a data or trailing-blank state
  assign trail_ty = (state_i == LX_OPERAND_DATA || state_i == LX_OPERAND_TRAIL) ?
                    TT_OPERAND : TT_OPCODE;

  always_comb begin
    nxt = state_i;
    n   = 2'd0;
    res = '0;
    case (state_i)
      LX_FIRST_LEAD, LX_OPCODE_LEAD, LX_OPERAND_LEAD: begin
        if (is_semi) begin
          nxt = LX_COMMENT;
        end else if (is_nl) begin
          nxt = LX_FIRST_LEAD;
        end else if (is_blank) begin
          nxt = state_i;
        end else if (state_i == LX_FIRST_LEAD && is_colon) begin
          // empty label
          res[0] = mk_res(RK_END, TT_LABEL, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPCODE_LEAD;
        end else if (state_i == LX_OPERAND_LEAD && is_comma) begin
          // empty operand
          res[0] = mk_res(RK_END, TT_OPERAND, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPERAND_LEAD;
        end else begin
          res[0] = mk_res(RK_CHAR, TT_LABEL, c);
          n      = 2'd1;
          nxt    = state_i + 4'd1;
        end
      end
      LX_FIRST_DATA, LX_OPCODE_DATA, LX_OPERAND_DATA: begin
        if (is_semi) begin
          res[0] = mk_res(RK_END, trail_ty, 8'd0);
          n      = 2'd1;
          nxt    = LX_COMMENT;
        end else if (is_nl) begin
          res[0] = mk_res(RK_END, trail_ty, 8'd0);
          n      = 2'd1;
          nxt    = LX_FIRST_LEAD;
        end else if (is_blank) begin
          nxt = state_i + 4'd1;
        end else if (state_i == LX_FIRST_DATA && is_colon) begin
          res[0] = mk_res(RK_END, TT_LABEL, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPCODE_LEAD;
        end else if (state_i == LX_OPERAND_DATA && is_comma) begin
          res[0] = mk_res(RK_END, TT_OPERAND, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPERAND_LEAD;
        end else begin
          res[0] = mk_res(RK_CHAR, TT_LABEL, c);
          n      = 2'd1;
        end
      end
      LX_FIRST_TRAIL, LX_OPCODE_TRAIL, LX_OPERAND_TRAIL: begin
        if (is_semi) begin
          res[0] = mk_res(RK_END, trail_ty, 8'd0);
          n      = 2'd1;
          nxt    = LX_COMMENT;
        end else if (is_nl) begin
          res[0] = mk_res(RK_END, trail_ty, 8'd0);
          n      = 2'd1;
          nxt    = LX_FIRST_LEAD;
        end else if (is_blank) begin
          nxt = state_i;
        end else if (state_i == LX_FIRST_TRAIL && is_colon) begin
          res[0] = mk_res(RK_END, TT_LABEL, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPCODE_LEAD;
        end else if (state_i == LX_OPERAND_TRAIL && is_comma) begin
          res[0] = mk_res(RK_END, TT_OPERAND, 8'd0);
          n      = 2'd1;
          nxt    = LX_OPERAND_LEAD;
        end else if (state_i == LX_OPERAND_TRAIL) begin
          // a second word inside one operand
          res[0] = mk_res(RK_ERROR, TT_LABEL, 8'd0);
          n      = 2'd1;
          nxt    = LX_ERROR;
        end else begin
          // close the opcode; this byte then opens the first operand, or ends it empty if a comma
          res[0] = mk_res(RK_END, TT_OPCODE, 8'd0);
          if (is_comma) begin
            res[1] = mk_res(RK_END, TT_OPERAND, 8'd0);
            nxt    = LX_OPERAND_LEAD;
          end else begin
            res[1] = mk_res(RK_CHAR, TT_LABEL, c);
            nxt    = LX_OPERAND_DATA;
          end
          n = 2'd2;
        end
      end
      LX_COMMENT: begin
        if (is_nl) begin
          nxt = LX_FIRST_LEAD;
        end
      end
      default: begin
        // error state and unused codes: drop the byte
        nxt = state_i;
      end
    endcase

    nxt_eot = nxt;
    if (item_i.end_of_text) begin
      if (nxt inside {LX_FIRST_DATA, LX_FIRST_TRAIL, LX_OPCODE_DATA, LX_OPCODE_TRAIL,
                      LX_OPERAND_DATA, LX_OPERAND_TRAIL}) begin
        res[n] = mk_res(RK_ABANDON, TT_LABEL, 8'd0);
        n      = n + 2'd1;
      end
      nxt_eot = LX_FIRST_LEAD;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last_result = 1'b1;
    end
  end

  assign state_o      = nxt_eot;
  assign bundle_o.res = res;
  assign bundle_o.cnt = n;

endmodule

@@ hw/rtl/assembly_line_tokenizer.sv @@
// Top level of the assembly line tokenizer: input register, lexer state, result queue.
//
// Source text enters one byte per transfer; each byte produces zero to three
// results (token characters, token ends, an error, an abandoned-token marker),
// the last one flagged by last_result. A byte is held in the input register,
// is lexed combinationally, and its results are loaded into a three-slot
// result register that hands out one result per cycle while out_ready_i is
// high. A new byte can be taken every cycle while the result register is free;
// a byte with results waits in the input register until all earlier results
// have been handed out. Bytes that produce no result pass even while earlier
// results wait.
module assembly_line_tokenizer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  altok_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output altok_pkg::out_item_t out_o
);
  import altok_pkg::*;

  logic       in_vld_q;
  in_item_t   in_q;
  logic [3:0] state_q;
  logic [3:0] lex_state;
  bundle_t    lex_bundle;
  out_item_t [MaxResults-1:0] res_q;
  logic [1:0] cnt_q;
  logic [1:0] idx_q;
  logic       pop, pop_last, bundle_free, fire, load;

  altok_lexer u_lexer (
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (lex_state),
    .bundle_o (lex_bundle)
  );

  assign pop         = out_valid_o && out_ready_i;
  assign pop_last    = pop && (idx_q == cnt_q - 2'd1);
  assign bundle_free = (cnt_q == 2'd0) || pop_last;
  // A byte with no results never waits on the result register
  assign fire        = in_vld_q && (bundle_free || lex_bundle.cnt == 2'd0);
  assign load        = fire && (lex_bundle.cnt != 2'd0);
  assign in_ready_o  = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= LX_FIRST_LEAD;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        state_q <= lex_state;
      end
      if (load) begin
        cnt_q <= lex_bundle.cnt;
        idx_q <= 2'd0;
      end else if (pop_last) begin
        cnt_q <= 2'd0;
        idx_q <= 2'd0;
      end else if (pop) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (load) begin
      res_q <= lex_bundle.res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = res_q[idx_q];

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (idx_q < cnt_q))
    else $error("result index beyond loaded count");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last_result == (idx_q == cnt_q - 2'd1)))
    else $error("last_result does not mark the final queued result");

  a_eot_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.end_of_text) |=> (state_q == LX_FIRST_LEAD))
    else $error("lexer not back at line start after end of text");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q == LX_ERROR && !in_q.end_of_text) |=> (state_q == LX_ERROR))
    else $error("error state left before end of text");

  a_load_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_o && idx_q == 2'd0))
    else $error("loaded results not presented from the first slot");

endmodule
